// ----- rtl/pfx_pkg.sv -----
`timescale 1ns / 1ps

package pfx_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DATA_W      = 32;
  localparam int CH_W        = 8;
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_DIV0  = 2'd2,
    ST_OVF   = 2'd3
  } status_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    latch;
    logic    acc;
    logic    push;
    logic    rd;
    logic    op_wb;
    logic    div_start;
    logic    div_wb;
    logic    set_err;
    status_t err_code;
    logic    emit;
  } pfx_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic             last;
    logic             err_any;
    logic             is_space;
    logic             is_op;
    logic             is_div;
    logic             in_number;
    logic             cnt_lt2;
    logic             full;
    logic             op2_zero;
    logic             div_done;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } pfx_sts_t;

endpackage

// ----- rtl/pfx_div.sv -----
`timescale 1ns / 1ps

module pfx_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pfx_pkg::DATA_W-1:0] dividend,
  input  logic [pfx_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [pfx_pkg::DATA_W-1:0] quotient
);

  localparam int W = pfx_pkg::DATA_W;

  logic [W-1:0]                    rem_r, rem_nxt;
  logic [W-1:0]                    quo_r, quo_nxt;
  logic [W-1:0]                    div_r, div_nxt;
  logic                            neg_r, neg_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [pfx_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [W:0]                      trial;
  logic                            na, nb;

  assign na = dividend[W-1];
  assign nb = divisor[W-1];
  assign trial = {rem_r, quo_r[W-1]} - {1'b0, div_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      // work on magnitudes, fix the sign at the end
      rem_nxt  = '0;
      quo_nxt  = na ? (W'(0) - dividend) : dividend;
      div_nxt  = nb ? (W'(0) - divisor) : divisor;
      neg_nxt  = na ^ nb;
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pfx_pkg::DIV_CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (W'(0) - quo_r) : quo_r;

endmodule

// ----- rtl/pfx_dp.sv -----
`timescale 1ns / 1ps

module pfx_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfx_pkg::pfx_cmd_t             cmd,
  output pfx_pkg::pfx_sts_t             sts,
  input  logic [pfx_pkg::CH_W-1:0]      in_ch,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfx_pkg::DATA_W-1:0]    out_value,
  output pfx_pkg::status_t              out_status
);

  localparam int W  = pfx_pkg::DATA_W;
  localparam int CW = pfx_pkg::CNT_W;
  localparam int AW = pfx_pkg::ADDR_W;

  logic [W-1:0]                mem [pfx_pkg::STACK_DEPTH];
  logic [W-1:0]                rd_data_r;
  logic [W-1:0]                tos_r, tos_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [W-1:0]                accum_r, accum_nxt;
  logic                        in_num_r, in_num_nxt;
  logic                        dd_r, dd_nxt;
  pfx_pkg::status_t            err_r, err_nxt;
  logic [pfx_pkg::CH_W-1:0]    ch_r;
  logic                        last_r;
  logic                        outv_r, outv_nxt;
  logic [W-1:0]                outval_r;
  pfx_pkg::status_t            outst_r;

  logic [CW-1:0]               cnt_m1, cnt_m2;
  logic                        is_digit, dd_eff, full;
  logic [W-1:0]                base, digit;
  logic [2*W-1:0]              prod;
  logic [W-1:0]                op_res;
  logic                        div_done;
  logic [W-1:0]                div_q;

  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_m2   = cnt_r - CW'(2);
  assign is_digit = (ch_r >= pfx_pkg::CH_ZERO) && (ch_r <= pfx_pkg::CH_NINE);
  assign dd_eff   = in_num_r & dd_r;
  assign base     = in_num_r ? accum_r : '0;
  assign digit    = W'(ch_r - pfx_pkg::CH_ZERO);
  assign full     = (cnt_r == CW'(pfx_pkg::STACK_DEPTH));
  assign prod     = rd_data_r * tos_r;

  always_comb begin
    case (ch_r)
      pfx_pkg::CH_PLUS:  op_res = rd_data_r + tos_r;
      pfx_pkg::CH_MINUS: op_res = rd_data_r - tos_r;
      default:           op_res = prod[W-1:0];
    endcase
  end

  pfx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rd_data_r),
    .divisor  (tos_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    tos_nxt    = tos_r;
    cnt_nxt    = cnt_r;
    accum_nxt  = accum_r;
    in_num_nxt = in_num_r;
    dd_nxt     = dd_r;
    err_nxt    = err_r;
    outv_nxt   = outv_r & ~out_ready;
    if (cmd.acc) begin
      in_num_nxt = 1'b1;
      dd_nxt     = dd_eff | ~is_digit;
      if (!dd_eff && is_digit) begin
        accum_nxt = (base << 3) + (base << 1) + digit;
      end else begin
        accum_nxt = base;
      end
    end
    if (cmd.push) begin
      if (!full) begin
        tos_nxt = accum_r;
        cnt_nxt = cnt_r + CW'(1);
      end
      in_num_nxt = 1'b0;
      dd_nxt     = 1'b0;
      accum_nxt  = '0;
    end
    if (cmd.op_wb) begin
      tos_nxt = op_res;
      cnt_nxt = cnt_m1;
    end
    if (cmd.div_wb) begin
      tos_nxt = div_q;
      cnt_nxt = cnt_m1;
    end
    if (cmd.set_err) begin
      err_nxt = cmd.err_code;
    end
    if (cmd.emit) begin
      outv_nxt   = 1'b1;
      cnt_nxt    = '0;
      accum_nxt  = '0;
      in_num_nxt = 1'b0;
      dd_nxt     = 1'b0;
      err_nxt    = pfx_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      accum_r  <= '0;
      in_num_r <= 1'b0;
      dd_r     <= 1'b0;
      err_r    <= pfx_pkg::ST_OK;
      outv_r   <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      accum_r  <= accum_nxt;
      in_num_r <= in_num_nxt;
      dd_r     <= dd_nxt;
      err_r    <= err_nxt;
      outv_r   <= outv_nxt;
    end
  end

  // top of stack lives in tos_r, the entries below it in the memory
  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    if (cmd.push && !full && (cnt_r != '0)) begin
      mem[cnt_m1[AW-1:0]] <= tos_r;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[cnt_m2[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ch_r   <= in_ch;
      last_r <= in_last;
    end
    if (cmd.emit) begin
      outval_r <= (cnt_r != '0) ? tos_r : '0;
      if (err_r != pfx_pkg::ST_OK) begin
        outst_r <= err_r;
      end else if (cnt_r == '0) begin
        outst_r <= pfx_pkg::ST_UNDER;
      end else begin
        outst_r <= pfx_pkg::ST_OK;
      end
    end
  end

  assign sts.last      = last_r;
  assign sts.err_any   = (err_r != pfx_pkg::ST_OK);
  assign sts.is_space  = (ch_r == pfx_pkg::CH_SPACE);
  assign sts.is_op     = (ch_r == pfx_pkg::CH_PLUS) || (ch_r == pfx_pkg::CH_MINUS) ||
                         (ch_r == pfx_pkg::CH_STAR) || (ch_r == pfx_pkg::CH_SLASH);
  assign sts.is_div    = (ch_r == pfx_pkg::CH_SLASH);
  assign sts.in_number = in_num_r;
  assign sts.cnt_lt2   = (cnt_r < CW'(2));
  assign sts.full      = full;
  assign sts.op2_zero  = (tos_r == '0);
  assign sts.div_done  = div_done;
  assign sts.out_free  = ~outv_r | out_ready;
  assign sts.count     = cnt_r;

  assign out_valid  = outv_r;
  assign out_value  = outval_r;
  assign out_status = outst_r;

endmodule

// ----- rtl/pfx_ctrl.sv -----
`timescale 1ns / 1ps

module pfx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfx_pkg::pfx_sts_t sts,
  output pfx_pkg::pfx_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEC  = 6'b000010,
    S_PUSH = 6'b000100,
    S_OPRD = 6'b001000,
    S_DIVW = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  state_t after_item;

  // where to go once the character's stack work is over
  assign after_item = sts.last ? S_FIN : S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.err_any) begin
          state_nxt = after_item;
        end else if (sts.is_space) begin
          state_nxt = sts.in_number ? S_PUSH : after_item;
        end else if (!sts.in_number && sts.is_op) begin
          if (sts.cnt_lt2) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = pfx_pkg::ST_UNDER;
            state_nxt    = after_item;
          end else begin
            cmd.rd    = 1'b1;
            state_nxt = S_OPRD;
          end
        end else begin
          cmd.acc   = 1'b1;
          state_nxt = sts.last ? S_PUSH : S_IDLE;
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (sts.full) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = pfx_pkg::ST_OVF;
        end
        state_nxt = after_item;
      end
      S_OPRD: begin
        if (!sts.is_div) begin
          cmd.op_wb = 1'b1;
          state_nxt = after_item;
        end else if (sts.op2_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = pfx_pkg::ST_DIV0;
          state_nxt    = after_item;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVW;
        end
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.div_wb = 1'b1;
          state_nxt  = after_item;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ----- rtl/postfix_expression_evaluator_unit.sv -----
`timescale 1ns / 1ps
// Postfix (RPN) expression evaluator, one ASCII character per input beat.
// Input channel: in_tdata carries the character, in_tlast marks the final
// character of an expression. Tokens are separated by spaces; + - * / at the
// start of a token are operators, anything else is a number token.
// Output channel: one beat per expression, sent after the beat with in_tlast:
// out_tdata is the top of the stack (0 if empty), out_tuser the status
// (0 ok, 1 underflow, 2 divide by zero, 3 overflow; the first error sticks).
// Each character passes the idle and decode states; one that ends a number
// adds the push state, an operator the operand-read state, and / then also
// waits in the divide state on the 32-step radix-2 divider. After the last
// character the finish state loads the output register once it is free.
// The output register parts the two sides: the next expression is taken
// while a result waits; only the next result waits on out_tready.
// Reset (synchronous, rst_n low) empties the stack, clears the number and
// error state and drops out_tvalid; the stack memory itself is not cleared.
module postfix_expression_evaluator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [1:0]  out_tuser   // [1:0] status
);

  pfx_pkg::pfx_cmd_t cmd;
  pfx_pkg::pfx_sts_t sts;
  pfx_pkg::status_t  out_status;

  pfx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfx_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_ch      (in_tdata),
    .in_last    (in_tlast),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (out_tdata),
    .out_status (out_status)
  );

  assign out_tuser = out_status;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.count <= pfx_pkg::CNT_W'(pfx_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_div_wb: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_wb |-> sts.div_done)
    else $error("quotient written before divider done");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (sts.count == '0) && !sts.err_any && !sts.in_number)
    else $error("state not cleared after result");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [31:0]      value;
    pfx_pkg::status_t status;
  } rpn_result_t;

  // mirrors the evaluator: operand stack, number token state and sticky error
  class rpn_scoreboard;
    logic [31:0]      stk [pfx_pkg::STACK_DEPTH];
    int unsigned      depth;
    logic [31:0]      accum;
    bit               in_num;
    bit               dig_done;
    pfx_pkg::status_t err;
    rpn_result_t      exp_q [$];
    int               errors;

    function new();
      errors = 0;
      clear_expr();
    endfunction

    function void clear_expr();
      depth    = 0;
      accum    = '0;
      in_num   = 1'b0;
      dig_done = 1'b0;
      err      = pfx_pkg::ST_OK;
    endfunction

    function void push_val(logic [31:0] v);
      if (depth >= pfx_pkg::STACK_DEPTH) begin
        err = pfx_pkg::ST_OVF;
        return;
      end
      stk[depth] = v;
      depth++;
    endfunction

    // quotient truncated toward zero, min / -1 wraps
    function logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = ma / mb;
      return (a[31] != b[31]) ? -q : q;
    endfunction

    function void apply_op(logic [7:0] c);
      logic [31:0] op1, op2, r;
      if (depth < 2) begin
        err = pfx_pkg::ST_UNDER;
        return;
      end
      op2 = stk[depth-1];
      op1 = stk[depth-2];
      if (c == pfx_pkg::CH_SLASH && op2 == 32'd0) begin
        err = pfx_pkg::ST_DIV0;
        return;
      end
      case (c)
        pfx_pkg::CH_PLUS:  r = op1 + op2;
        pfx_pkg::CH_MINUS: r = op1 - op2;
        pfx_pkg::CH_STAR:  r = op1 * op2;
        default:           r = div_trunc(op1, op2);
      endcase
      depth -= 2;
      push_val(r);
    endfunction

    function void end_num();
      if (in_num) begin
        push_val(accum);
        in_num   = 1'b0;
        dig_done = 1'b0;
        accum    = '0;
      end
    endfunction

    function void take_char(logic [7:0] c);
      bit is_op;
      is_op = (c == pfx_pkg::CH_PLUS) || (c == pfx_pkg::CH_MINUS) ||
              (c == pfx_pkg::CH_STAR) || (c == pfx_pkg::CH_SLASH);
      if (c == pfx_pkg::CH_SPACE) begin
        end_num();
        return;
      end
      if (!in_num) begin
        if (is_op) begin
          apply_op(c);
          return;
        end
        in_num   = 1'b1;
        dig_done = 1'b0;
        accum    = '0;
      end
      if (!dig_done) begin
        if (c >= pfx_pkg::CH_ZERO && c <= pfx_pkg::CH_NINE)
          accum = accum * 32'd10 + (c - pfx_pkg::CH_ZERO);
        else dig_done = 1'b1;
      end
    endfunction

    function void note_char(logic [7:0] c, logic l);
      rpn_result_t r;
      if (err == pfx_pkg::ST_OK) begin
        take_char(c);
        if (l && err == pfx_pkg::ST_OK) end_num();
      end
      if (l) begin
        r.value = (depth > 0) ? stk[depth-1] : 32'd0;
        if (err != pfx_pkg::ST_OK) r.status = err;
        else if (depth == 0) r.status = pfx_pkg::ST_UNDER;
        else r.status = pfx_pkg::ST_OK;
        exp_q.push_back(r);
        clear_expr();
      end
    endfunction

    function void check_result(logic [31:0] v, logic [1:0] s);
      rpn_result_t r;
      if (exp_q.size() == 0) begin
        $error("result beat with no expression pending: value %0d status %0d",
               $signed(v), s);
        errors++;
        return;
      end
      r = exp_q.pop_front();
      if (v !== r.value) begin
        $error("value mismatch: expected %0d, actual %0d", $signed(r.value), $signed(v));
        errors++;
      end
      if (s !== r.status) begin
        $error("status mismatch: expected %0d, actual %0d", r.status, s);
        errors++;
      end
    endfunction

    function int pending();
      return exp_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] ch
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] value
  logic [1:0]  out_tuser;  // [1:0] status

  rpn_scoreboard sb = new();
  logic [7:0]    expr_q [$];
  int            sent;
  bit            quiet = 1'b0;
  bit            hold_req = 1'b0;

  string directed_exprs [18] = '{
    "3 4 +", "10 3 -", "6 7 *", "7 2 /", "0 7 - 2 /", "0 2147483648 - 0 1 - /",
    "5 0 /", "+", " ", "12abc 3 +", "4 5+", "4 5 +6", "  8   9  *  ",
    "4294967295 1 +", "99999999999", "1 0 / 5 +", "1 2 3", "9 *"
  };

  postfix_expression_evaluator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return pfx_pkg::CH_PLUS;
      1:       return pfx_pkg::CH_MINUS;
      2:       return pfx_pkg::CH_STAR;
      default: return pfx_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic void put_sep();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
    repeat (n) expr_q.push_back(pfx_pkg::CH_SPACE);
  endfunction

  function automatic void put_number();
    int nd;
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0:       nd = $urandom_range(8, 12);
      1:       nd = 0;
      default: nd = $urandom_range(1, 4);
    endcase
    if (nd == 0) expr_q.push_back(pfx_pkg::CH_ZERO);
    for (int i = 0; i < nd; i++)
      expr_q.push_back(pfx_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    // trailing junk inside the token is skipped
    if ($urandom_range(0, 9) == 0) begin
      b = 8'($urandom_range(0, 255));
      if (b == pfx_pkg::CH_SPACE) b = 8'h41;
      expr_q.push_back(b);
    end
  endfunction

  function automatic void gen_wellformed(int max_opnds);
    int left, dep;
    bit first;
    left  = $urandom_range(1, max_opnds);
    dep   = 0;
    first = 1'b1;
    if ($urandom_range(0, 7) == 0) put_sep();
    while (left > 0 || dep > 1) begin
      if (!first) put_sep();
      first = 1'b0;
      if (dep >= 2 && (left == 0 || $urandom_range(0, 2) == 0)) begin
        expr_q.push_back(pick_op());
        dep--;
      end else begin
        put_number();
        dep++;
        left--;
      end
    end
    if ($urandom_range(0, 7) == 0) put_sep();
  endfunction

  function automatic void gen_noise();
    int len;
    len = $urandom_range(1, 16);
    repeat (len) begin
      case ($urandom_range(0, 3))
        0:       expr_q.push_back(8'($urandom_range(0, 255)));
        1:       expr_q.push_back(pfx_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        2:       expr_q.push_back(pfx_pkg::CH_SPACE);
        default: expr_q.push_back(pick_op());
      endcase
    end
  endfunction

  function automatic void gen_broken();
    case ($urandom_range(0, 2))
      0: begin
        expr_q.push_back(pick_op());
        put_sep();
        gen_wellformed(4);
      end
      1: begin
        gen_wellformed(4);
        put_sep();
        expr_q.push_back(pick_op());
      end
      default: begin
        gen_wellformed(4);
        expr_q.push_back(pick_op());
        expr_q.push_back(pick_op());
      end
    endcase
  endfunction

  // stack near its depth limit, then folded back down
  function automatic void gen_deep();
    int n;
    n = $urandom_range(pfx_pkg::STACK_DEPTH - 4, pfx_pkg::STACK_DEPTH + 4);
    for (int i = 0; i < n; i++) begin
      expr_q.push_back(pfx_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
      expr_q.push_back(pfx_pkg::CH_SPACE);
    end
    for (int i = 1; i < n; i++) begin
      expr_q.push_back(($urandom_range(0, 1) == 0) ? pfx_pkg::CH_PLUS : pfx_pkg::CH_STAR);
      expr_q.push_back(pfx_pkg::CH_SPACE);
    end
  endfunction

  task automatic send_beat(input logic [7:0] c, input logic l);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_expr();
    for (int i = 0; i < expr_q.size(); i++) send_beat(expr_q[i], i == expr_q.size() - 1);
    sent += expr_q.size();
    expr_q.delete();
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    foreach (directed_exprs[i]) begin
      put_str(directed_exprs[i]);
      send_expr();
    end
    // nul byte starts a number token worth zero
    expr_q.push_back(8'h00);
    put_str(" 7 +");
    send_expr();
    put_str("5 ");
    expr_q.push_back(8'hFF);
    put_str("3");
    send_expr();
    // exactly full stack, then one push too many
    for (int i = 0; i < pfx_pkg::STACK_DEPTH - 1; i++) put_str("1 ");
    put_str("1");
    send_expr();
    for (int i = 0; i < pfx_pkg::STACK_DEPTH; i++) put_str("1 ");
    put_str("2");
    send_expr();
  endtask

  task automatic run_random();
    int n_expr;
    int pick;
    n_expr = 0;
    while (sent < 1600) begin
      quiet = (sent > 1350);
      if (n_expr == 25) begin
        hold_req = 1'b1;
        repeat (5) begin
          gen_wellformed(6);
          send_expr();
        end
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) gen_wellformed(6);
      else if (pick < 75) gen_wellformed(16);
      else if (pick < 87) gen_noise();
      else if (pick < 99) gen_broken();
      else gen_deep();
      send_expr();
      n_expr++;
      if (!quiet && $urandom_range(0, 19) == 0) drain_results();
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    drain_results();
    run_random();
    drain_results();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
